// ----- src/dfc_pkg.sv -----
// Shared constants, codes and control types of the damped feedback comb filter.
`timescale 1ns / 1ps
`default_nettype none

package dfc_pkg;

    // Default sizes, handed down through the top level parameters
    localparam int MAX_DELAY_DEF   = 2048;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int LEN_CFG_W  = 12;
    localparam int FB_W       = 16;
    localparam int COEF_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_DAMP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 2'd2;

    // Q1.16 unity
    localparam logic [COEF_W-1:0] Q_ONE = 17'h10000;

    // Request action codes
    localparam logic ACT_PROCESS = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LP_A,
        S_LP_B,
        S_WRITE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // capture sample, issue store read
        logic clear;   // reset position and fill count
        logic lp_a;    // delayed * (1 - damp)
        logic lp_b;    // state * damp, update lowpass state
        logic write;   // state * feedback + input, write store, load output
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- src/dfc_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module dfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/dfc_ctrl.sv -----
// Controller state machine: request sequencing and output valid.
`timescale 1ns / 1ps
`default_nettype none

module dfc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic            i_action,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output dfc_pkg::t_dp_cmd     o_cmd
);

    import dfc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_accept;
    logic   out_taken;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_taken   = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = out_taken ? 1'b0 : r_out_valid;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_action == ACT_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_LP_A;
                    end
                end
            end
            S_LP_A: begin
                o_cmd.lp_a = 1'b1;
                n_state    = S_LP_B;
            end
            S_LP_B: begin
                o_cmd.lp_b = 1'b1;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                // wait until the output register is free
                if (!r_out_valid || out_taken) begin
                    o_cmd.write = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/dfc_datapath.sv -----
// Datapath: configuration, shared multiplier, lowpass state, store and position.
`timescale 1ns / 1ps
`default_nettype none

module dfc_datapath #(
    parameter int MAX_DELAY   = dfc_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = dfc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [dfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dfc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire dfc_pkg::t_dp_cmd                  i_cmd,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    output logic signed [SAMPLE_BITS-1:0]          o_sample_out
);

    import dfc_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int POS_W = $clog2(MAX_DELAY);
    localparam int LEN_W = $clog2(MAX_DELAY + 1);
    localparam int PW    = SB + COEF_W + 1;   // product width
    localparam int TW    = SB + 2;            // product >>> 16
    localparam int AW    = SB + 3;            // sum width

    localparam logic signed [AW-1:0] SMAX_W = {4'b0000, {(SB-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN_W = {4'b1111, {(SB-1){1'b0}}};

    // Configuration registers
    logic [COEF_W-1:0] r_damp;
    logic [FB_W-1:0]   r_fb;
    logic [LEN_W-1:0]  r_len;

    // Working registers
    logic [POS_W-1:0]        r_pos;
    logic [LEN_W-1:0]        r_fill;    // entries written since the last clear or length change
    logic signed [SB-1:0]    r_lp;
    logic signed [SB-1:0]    r_x;
    logic signed [SB-1:0]    r_delayed;
    logic signed [TW-1:0]    r_term;
    logic signed [SB-1:0]    r_out;

    logic [COEF_W-1:0]       damp_clamped;
    logic [LEN_CFG_W-1:0]    len_raw;
    logic [31:0]             len_eff;
    logic                    len_change;
    logic [COEF_W-1:0]       one_minus;
    logic signed [SB-1:0]    rd_data;
    logic                    rd_ok;
    logic signed [SB-1:0]    delayed;
    logic signed [SB-1:0]    mul_a;
    logic [COEF_W-1:0]       mul_b;
    logic signed [PW-1:0]    prod;
    logic signed [TW-1:0]    prod_sh;
    logic signed [AW-1:0]    lp_sum;
    logic signed [AW-1:0]    wr_sum;
    logic signed [SB-1:0]    lp_sat;
    logic signed [SB-1:0]    wr_sat;
    logic [31:0]             pos_inc;
    logic [POS_W-1:0]        pos_next;

    // Configuration decode with clamping
    assign damp_clamped = (i_cfg_data > Q_ONE) ? Q_ONE : i_cfg_data;
    assign len_raw      = i_cfg_data[LEN_CFG_W-1:0];
    always_comb begin
        len_eff = 32'(len_raw);
        if (len_eff == 32'd0) begin
            len_eff = 32'd1;
        end else if (len_eff > 32'(MAX_DELAY)) begin
            len_eff = 32'(MAX_DELAY);
        end
    end
    assign len_change = i_cfg_we && (i_cfg_index == CFG_LENGTH)
                     && (len_eff[LEN_W-1:0] != r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp <= '0;
            r_fb   <= '0;
            r_len  <= LEN_W'(MAX_DELAY);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_DAMP) begin
                r_damp <= damp_clamped;
            end
            if (i_cfg_index == CFG_FEEDBACK) begin
                r_fb <= i_cfg_data[FB_W-1:0];
            end
            if (i_cfg_index == CFG_LENGTH) begin
                r_len <= len_eff[LEN_W-1:0];
            end
        end
    end

    // Delay store; entries at or above the fill count read as zero
    dfc_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_DELAY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_pos),
        .i_wdata (wr_sat),
        .i_re    (i_cmd.load),
        .i_raddr (r_pos),
        .o_rdata (rd_data)
    );

    assign rd_ok   = (32'(r_pos) < 32'(r_fill));
    assign delayed = rd_ok ? rd_data : '0;

    // Shared multiplier operand select
    assign one_minus = Q_ONE - r_damp;
    always_comb begin
        priority if (i_cmd.lp_a) begin
            mul_a = delayed;
            mul_b = one_minus;
        end else if (i_cmd.lp_b) begin
            mul_a = r_lp;
            mul_b = r_damp;
        end else begin
            mul_a = r_lp;
            mul_b = {1'b0, r_fb};
        end
    end

    assign prod    = mul_a * $signed({1'b0, mul_b});
    assign prod_sh = prod[PW-1:16];

    // Sums and saturation
    assign lp_sum = {r_term[TW-1], r_term} + {prod_sh[TW-1], prod_sh};
    assign wr_sum = {{3{r_x[SB-1]}}, r_x} + {prod_sh[TW-1], prod_sh};

    always_comb begin
        priority if (lp_sum > SMAX_W) begin
            lp_sat = SMAX_W[SB-1:0];
        end else if (lp_sum < SMIN_W) begin
            lp_sat = SMIN_W[SB-1:0];
        end else begin
            lp_sat = lp_sum[SB-1:0];
        end
        priority if (wr_sum > SMAX_W) begin
            wr_sat = SMAX_W[SB-1:0];
        end else if (wr_sum < SMIN_W) begin
            wr_sat = SMIN_W[SB-1:0];
        end else begin
            wr_sat = wr_sum[SB-1:0];
        end
    end

    // Position advance with wrap at the length in use
    assign pos_inc  = 32'(r_pos) + 32'd1;
    assign pos_next = (pos_inc >= 32'(r_len)) ? '0 : pos_inc[POS_W-1:0];

    // Control state: position, fill count, lowpass state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
            r_lp   <= '0;
        end else if (i_cmd.clear || len_change) begin
            r_pos  <= '0;
            r_fill <= '0;
        end else begin
            if (i_cmd.lp_b) begin
                r_lp <= lp_sat;
            end
            if (i_cmd.write) begin
                r_pos <= pos_next;
                if (32'(r_pos) == 32'(r_fill)) begin
                    r_fill <= r_fill + LEN_W'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.lp_a) begin
            r_delayed <= delayed;
            r_term    <= prod_sh;
        end
        if (i_cmd.write) begin
            r_out <= r_delayed;
        end
    end

    assign o_sample_out = r_out;

endmodule

`default_nettype wire

// ----- src/damped_feedback_comb_filter.sv -----
// Top level of the damped (lowpass feedback) comb filter.
`timescale 1ns / 1ps
`default_nettype none

// A process request returns the sample stored MAX_DELAY-deep circular store at
// the current position, updates the one-pole lowpass state and writes back
// input + state * feedback, saturated. It first accepts the request and starts
// the store read, then takes three steps through the single shared multiplier
// (delayed * (1 - damp), state * damp, state * feedback); the write step waits
// while the previous result is still held in the output register. A clear
// request gives no result. Clearing and length changes reset a fill count, so
// no sweep of the store is needed: entries not written since the last clear
// read as zero. Configuration writes are always ready and are to be issued
// only while the filter is idle.

module damped_feedback_comb_filter #(
    parameter int MAX_DELAY   = dfc_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = dfc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [dfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dfc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_action,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]          o_sample_out
);

    import dfc_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    dfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    dfc_datapath #(
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out)
    );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench of the damped feedback comb filter with a scoreboard class.
`timescale 1ns / 1ps

// Tracks the filter's store, position and lowpass state, and keeps the samples due out.
class comb_scoreboard;
    localparam int DEPTH = dfc_pkg::MAX_DELAY_DEF;

    logic signed [15:0] delay_line [DEPTH];
    int unsigned        tap;
    longint             smooth;
    longint             damp_q;
    longint             gain_q;
    int unsigned        span;
    logic signed [15:0] due_samples [$];
    int                 failures;
    int                 reported;

    function new();
        wipe();
        smooth   = 0;
        damp_q   = 0;
        gain_q   = 0;
        span     = DEPTH;
        failures = 0;
        reported = 0;
    endfunction

    function void wipe();
        foreach (delay_line[i]) delay_line[i] = '0;
        tap = 0;
    endfunction

    function logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Register write, with the same clamping the filter applies
    function void set_register(logic [dfc_pkg::CFG_IDX_W-1:0] idx,
                               logic [dfc_pkg::CFG_DATA_W-1:0] data);
        int unsigned n;
        case (idx)
            dfc_pkg::CFG_DAMP: begin
                damp_q = (data > dfc_pkg::Q_ONE) ? longint'(dfc_pkg::Q_ONE) : longint'(data);
            end
            dfc_pkg::CFG_FEEDBACK: begin
                gain_q = longint'(data[15:0]);
            end
            dfc_pkg::CFG_LENGTH: begin
                n = 32'(data[11:0]);
                if (n < 1) n = 1;
                if (n > DEPTH) n = DEPTH;
                // only a real change of length empties the store
                if (n != span) begin
                    span = n;
                    wipe();
                end
            end
            default: ;
        endcase
    endfunction

    // Accepted request: clear, or one pass through the comb
    function void note_request(logic act, logic signed [15:0] x);
        longint delayed;
        longint lp;
        longint w;
        if (act == dfc_pkg::ACT_CLEAR) begin
            wipe();
            return;
        end
        if (tap >= span) tap = 0;
        delayed = longint'(delay_line[tap]);
        lp = ((delayed * (65536 - damp_q)) >>> 16) + ((smooth * damp_q) >>> 16);
        smooth = longint'(clip16(lp));
        w = longint'(x) + ((smooth * gain_q) >>> 16);
        delay_line[tap] = clip16(w);
        tap++;
        if (tap >= span) tap = 0;
        due_samples.push_back(delayed[15:0]);
    endfunction

    function void check_result(logic signed [15:0] got);
        logic signed [15:0] want;
        if (due_samples.size() == 0) begin
            failures++;
            if (reported < 10) begin
                reported++;
                $display("unexpected result: sample_out %0d", got);
            end
            return;
        end
        want = due_samples.pop_front();
        if (got !== want) begin
            failures++;
            if (reported < 10) begin
                reported++;
                $display("sample_out mismatch: expected %0d, actual %0d", want, got);
            end
        end
    endfunction

    function int pending();
        return due_samples.size();
    endfunction

    // Samples never delivered count as failures
    function int final_failures();
        if (due_samples.size() != 0) begin
            $display("%0d expected results never arrived", due_samples.size());
            failures += due_samples.size();
        end
        return failures;
    endfunction
endclass

module testbench;
    import dfc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    logic                   i_action    = ACT_PROCESS;
    logic signed [15:0]     i_sample_in = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [15:0]     o_sample_out;

    comb_scoreboard sb = new();

    bit calm         = 1'b0;   // no idling on either side
    bit pressure_req = 1'b0;   // ask the sink for a long hold-off

    damped_feedback_comb_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, data);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] d, f, l);
        if ($urandom_range(0, 2) == 0) write_register(CFG_SPARE, 17'($urandom));
        write_register(CFG_DAMP, d);
        write_register(CFG_FEEDBACK, f);
        write_register(CFG_LENGTH, l);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one request after a random gap, hold it until taken
    task automatic send_request(input logic act, input logic [15:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid  <= 1'b0;
            i_action    <= 1'($urandom);
            i_sample_in <= 16'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_sample_in <= smp;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(act, smp);
    endtask

    // Stop requests, collect all results, let a trailing clear finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Result sink: check accepted results and drive stall
    initial begin : result_sink
        int stall_left;
        int flow_left;
        stall_left = 0;
        flow_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_sample_out);
            if (pressure_req) begin
                pressure_req = 1'b0;
                stall_left   = 400;
            end else if (stall_left == 0 && flow_left == 0) begin
                flow_left  = $urandom_range(1, 8);
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                flow_left--;
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] len_raw;
        logic [CFG_DATA_W-1:0] damp_raw;
        logic [CFG_DATA_W-1:0] gain_raw;
        logic                  act;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No damping, full feedback: store write saturates at the maximum
        configure(17'd0, 17'd65535, 17'd3);
        send_request(ACT_PROCESS, 16'h7FFF);
        send_request(ACT_PROCESS, 16'h7FFF);
        send_request(ACT_PROCESS, 16'h7FFF);
        send_request(ACT_PROCESS, 16'h7FFF);
        send_request(ACT_PROCESS, 16'h8000);
        send_request(ACT_PROCESS, 16'h8000);
        send_request(ACT_PROCESS, 16'h8000);
        send_request(ACT_PROCESS, 16'h0001);
        settle();

        // Odd damp with the store full of minimum: lowpass sum drops below range
        configure(17'd1, 17'd65535, 17'd2);
        repeat (6) send_request(ACT_PROCESS, 16'h8000);
        settle();

        // Length zero acts as one; clear mid-stream keeps the lowpass state
        configure(17'd32768, 17'd32768, 17'h1F000);
        send_request(ACT_PROCESS, 16'd100);
        send_request(ACT_PROCESS, -16'sd100);
        send_request(ACT_CLEAR, 16'h5A5A);
        send_request(ACT_PROCESS, 16'd5);
        send_request(ACT_PROCESS, 16'hFFFF);
        settle();

        // Damp above one and length above the store depth are clamped
        configure(17'h1FFFF, 17'h10000, 17'd4095);
        send_request(ACT_PROCESS, 16'h1234);
        send_request(ACT_PROCESS, 16'h8000);
        send_request(ACT_PROCESS, 16'h7FFF);
        settle();
        len_raw = 17'd4095;

        // Random phases under varied settings
        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(0, 4))
                0: damp_raw = 17'd0;
                1: damp_raw = Q_ONE;
                2: damp_raw = 17'($urandom_range(65537, 131071));
                default: damp_raw = 17'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 3))
                0: gain_raw = 17'd0;
                1: gain_raw = 17'd65535;
                default: gain_raw = 17'($urandom_range(0, 65535));
            endcase
            gain_raw[16] = 1'($urandom);
            case ($urandom_range(0, 9))
                0: ;
                1: len_raw = 17'd2048;
                2: len_raw = {5'($urandom), 12'd0};
                3: len_raw = {5'($urandom), 12'($urandom_range(2049, 4095))};
                default: len_raw = {5'($urandom), 12'($urandom_range(1, 16))};
            endcase
            configure(damp_raw, gain_raw, len_raw);
            calm = (p == 3 || p == 6);
            if (p == 1 || p == 5) pressure_req = 1'b1;
            for (int k = 0; k < 200; k++) begin
                act = ($urandom_range(0, 24) == 0) ? ACT_CLEAR : ACT_PROCESS;
                send_request(act, pick_sample());
            end
            settle();
            calm = 1'b0;
        end

        repeat (20) @(posedge i_clk);
        if (sb.final_failures() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule

// ----- damped_feedback_comb_filter.f -----
src/dfc_pkg.sv
src/dfc_ram.sv
src/dfc_ctrl.sv
src/dfc_datapath.sv
src/damped_feedback_comb_filter.sv
test/testbench.sv
